// ===== sv/nrg_pkg.sv =====
package nrg_pkg;

    localparam int FRAC_DIGITS_MAX = 5;

    localparam logic [1:0] KIND_RMC  = 2'd0;
    localparam logic [1:0] KIND_GSV  = 2'd1;
    localparam logic [1:0] KIND_SKIP = 2'd2;

    localparam logic [1:0] HDR_NONE = 2'd0;
    localparam logic [1:0] HDR_RMC  = 2'd1;
    localparam logic [1:0] HDR_GSV  = 2'd2;

    localparam logic [1:0] PH_LEAD = 2'd0;
    localparam logic [1:0] PH_INT  = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;
    localparam logic [1:0] PH_FRAC = 2'd3;

    localparam logic CFG_SNR_THR   = 1'b0;
    localparam logic CFG_GOOD_SATS = 1'b1;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_W     = 8'h57;

    localparam logic [6:0]  SNR_CAP     = 7'd127;
    localparam int          DEG_CAP     = 99999;     // 9999999 / 100
    localparam int          MIN_SCALE   = 100000;
    localparam int          DEG_SCALE   = 1000000;
    localparam int          DIV6_M      = 22369621;  // floor(2^27 / 6)
    localparam int          DIV6_SHIFT  = 27;
    localparam logic [28:0] LAT_LIMIT   = 29'd90000000;
    localparam logic [28:0] LON_LIMIT   = 29'd180000000;

    typedef struct packed {
        logic [16:0] d;    // whole degrees
        logic [6:0]  r;    // whole minutes
        logic [16:0] f;    // minute fraction digits
        logic [2:0]  k;    // number of fraction digits
        logic        neg;
        logic [23:0] pr;
        logic [16:0] pf;
        logic [23:0] x;
        logic [36:0] dm;
        logic [20:0] q;
        logic [28:0] mag;
    } t_coord;

    typedef struct packed {
        logic [1:0]  kind;
        logic        sat_ok;
        logic [47:0] td;
        logic [6:0]  hours;
        logic [6:0]  minutes;
        logic [6:0]  seconds;
        logic [6:0]  day;
        logic [6:0]  month;
        logic [6:0]  year;
        t_coord      lat;
        t_coord      lon;
    } t_res;

    function automatic logic [7:0] hdr_char(input logic gsv, input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h24;
            3'd1:    ch = 8'h47;
            3'd2:    ch = 8'h50;
            3'd3:    ch = gsv ? 8'h47 : 8'h52;
            3'd4:    ch = gsv ? 8'h53 : 8'h4D;
            3'd5:    ch = gsv ? 8'h56 : 8'h43;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [16:0] pow10(input logic [2:0] n);
        logic [16:0] p;
        case (n)
            3'd0:    p = 17'd1;
            3'd1:    p = 17'd10;
            3'd2:    p = 17'd100;
            3'd3:    p = 17'd1000;
            3'd4:    p = 17'd10000;
            3'd5:    p = 17'd100000;
            default: p = 17'd1;
        endcase
        return p;
    endfunction

    // appends one integer digit to degrees/minutes kept apart; /100 via *41>>12
    function automatic logic [23:0] coord_digit(input logic [16:0] d, input logic [6:0] r,
                                                input logic [3:0] dv);
        logic [9:0]  t;
        logic [15:0] prod;
        logic [3:0]  hi;
        logic [6:0]  lo;
        logic [20:0] nd;
        t    = 10'(r) * 10'd10 + 10'(dv);
        prod = 16'(t) * 16'd41;
        hi   = 4'(prod >> 12);
        lo   = 7'(t - 10'(hi) * 10'd100);
        nd   = 21'(d) * 21'd10 + 21'(hi);
        if (nd > 21'(DEG_CAP)) begin
            return {17'(DEG_CAP), 7'd99};
        end
        return {nd[16:0], lo};
    endfunction

    function automatic logic [6:0] pair_val(input logic [3:0] a, input logic [3:0] b,
                                           input logic [6:0] lo, input logic [6:0] hi);
        logic [6:0] v;
        v = 7'(a) * 7'd10 + 7'(b);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    function automatic t_coord coord_s1(input t_coord c);
        t_coord o;
        o    = c;
        o.pr = 24'(c.r) * 24'(MIN_SCALE);
        o.pf = 17'(34'(c.f) * 34'(pow10(3'(FRAC_DIGITS_MAX) - c.k)));
        return o;
    endfunction

    // minutes in 1e-5 units plus 3: q = floor(x / 6) rounds to micro-degrees
    function automatic t_coord coord_s2(input t_coord c);
        t_coord o;
        o    = c;
        o.x  = c.pr + 24'(c.pf) + 24'd3;
        o.dm = 37'(c.d) * 37'(DEG_SCALE);
        return o;
    endfunction

    function automatic t_coord coord_s3(input t_coord c);
        t_coord      o;
        logic [48:0] prod;
        o    = c;
        prod = 49'(c.x) * 49'(DIV6_M);
        o.q  = 21'(prod >> DIV6_SHIFT);
        return o;
    endfunction

    function automatic t_coord coord_s4(input t_coord c);
        t_coord      o;
        logic [24:0] rem;
        o   = c;
        rem = 25'(c.x) - 25'(c.q) * 25'd6;
        if (rem >= 25'd6) begin
            o.q = c.q + 21'd1;
        end
        return o;
    endfunction

    function automatic t_coord coord_s5(input t_coord c, input logic [28:0] lim);
        t_coord      o;
        logic [36:0] val;
        o     = c;
        val   = c.dm + 37'(c.q);
        o.mag = (val > 37'(lim)) ? lim : val[28:0];
        return o;
    endfunction

endpackage

// ===== sv/nmea_rmc_gsv_parser.sv =====
// Channel   Valid        Stall        Payload
// input     i_in_valid   o_in_stall   i_text_byte
// output    o_out_valid  i_out_stall  o_line_kind, o_hours ... o_satellites_ok
//
// One byte per cycle is taken while the pipe is not stalled. A byte goes to an
// input register, the next cycle updates the field state, and a line end runs
// six more register stages (minute split products, divide by six, saturation,
// sign) to the output register. Reset is synchronous, active low, and gives the
// default registers. A stalled result freezes the whole pipe, so the input
// stalls only while a result waits in the output register.
module nmea_rmc_gsv_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_text_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_line_kind,
    output logic [4:0]  o_hours,
    output logic [5:0]  o_minutes,
    output logic [5:0]  o_seconds,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month,
    output logic [6:0]  o_year_two_digit,
    output logic signed [27:0] o_latitude_udeg,
    output logic signed [28:0] o_longitude_udeg,
    output logic        o_satellites_ok
);

    logic en;

    logic [6:0] r_thr;
    logic [3:0] r_need;

    logic       r_in_v;
    logic [7:0] r_in_byte;

    logic [4:0]  r_fidx, n_fidx;
    logic [1:0]  r_hdr, n_hdr;
    logic        r_past, n_past;
    logic [2:0]  r_pos, n_pos;
    logic [1:0]  r_phase, n_phase;
    logic        r_neg, n_neg;
    logic        r_may_rmc, n_may_rmc;
    logic        r_may_gsv, n_may_gsv;
    logic        r_dot, n_dot;
    logic [3:0]  r_td [0:11];
    logic [3:0]  n_td [0:11];
    logic [1:0]  r_hemi, n_hemi;
    logic [3:0]  r_left, n_left;
    logic [6:0]  r_sats, n_sats;
    logic [3:0]  r_good, n_good;
    logic [6:0]  r_snr, n_snr;
    logic [6:0]  r_total, n_total;
    logic [2:0]  r_fcnt, n_fcnt;
    logic [16:0] r_lat_d, n_lat_d, r_lon_d, n_lon_d;
    logic [6:0]  r_lat_r, n_lat_r, r_lon_r, n_lon_r;
    logic [16:0] r_lat_f, n_lat_f, r_lon_f, n_lon_f;
    logic [2:0]  r_lat_k, n_lat_k, r_lon_k, n_lon_k;

    logic        n_e0_v;
    nrg_pkg::t_res n_e0;

    logic [5:0]    r_pv;
    nrg_pkg::t_res r_pipe [0:5];
    nrg_pkg::t_res n_pipe [1:5];

    logic [7:0]  c;
    logic        cont, gsvl, dig, fe, by_comma, nl, act;
    logic        coord, skip, took_sign, num_int, num_frac, snr_good;
    logic [1:0]  ph;
    logic [3:0]  dv;
    logic [6:0]  v;
    logic [6:0]  tot;
    logic [10:0] snr_t;
    logic [23:0] cd;

    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= 7'd30;
            r_need <= 4'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                nrg_pkg::CFG_SNR_THR:   r_thr  <= i_cfg_data;
                nrg_pkg::CFG_GOOD_SATS: r_need <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (en) begin
            r_in_v <= i_in_valid;
        end
        if (en) begin
            r_in_byte <= i_text_byte;
        end
    end

    always_comb begin
        n_fidx = r_fidx;  n_hdr = r_hdr;  n_past = r_past;  n_pos = r_pos;
        n_phase = r_phase;  n_neg = r_neg;  n_may_rmc = r_may_rmc;  n_may_gsv = r_may_gsv;
        n_dot = r_dot;  n_td = r_td;  n_hemi = r_hemi;  n_left = r_left;  n_sats = r_sats;
        n_good = r_good;  n_snr = r_snr;  n_total = r_total;  n_fcnt = r_fcnt;
        n_lat_d = r_lat_d;  n_lat_r = r_lat_r;  n_lat_f = r_lat_f;  n_lat_k = r_lat_k;
        n_lon_d = r_lon_d;  n_lon_r = r_lon_r;  n_lon_f = r_lon_f;  n_lon_k = r_lon_k;
        n_e0_v = 1'b0;
        n_e0   = '0;

        c        = r_in_byte;
        dv       = c[3:0];
        dig      = (c >= 8'h30) && (c <= 8'h39);
        cont     = (r_left != 4'd0);
        gsvl     = cont || (r_hdr == nrg_pkg::HDR_GSV);
        fe       = 1'b0;
        by_comma = 1'b0;
        nl       = 1'b0;
        act      = 1'b0;
        v        = r_neg ? 7'd0 : r_snr;
        snr_good = (r_neg ? (r_snr == 7'd0) : 1'b1) && (r_snr >= r_thr);
        tot      = 7'd0;
        cd       = '0;
        snr_t    = '0;

        if (r_in_v) begin
            if (c == nrg_pkg::CH_LF) begin
                nl = 1'b1;
                fe = !r_past;
            end else if (!r_past) begin
                if (c == nrg_pkg::CH_STAR && gsvl) begin
                    fe       = 1'b1;
                    by_comma = 1'b1;
                    n_past   = 1'b1;
                end else if (c == nrg_pkg::CH_COMMA) begin
                    fe       = 1'b1;
                    by_comma = 1'b1;
                end else begin
                    act = 1'b1;
                end
            end
        end

        // field end
        if (fe) begin
            if (r_fidx == 5'd0 && !cont) begin
                n_hdr = nrg_pkg::HDR_NONE;
                if (by_comma && r_pos == 3'd6) begin
                    n_hdr = r_may_rmc ? nrg_pkg::HDR_RMC :
                            (r_may_gsv ? nrg_pkg::HDR_GSV : nrg_pkg::HDR_NONE);
                end
                if (n_hdr == nrg_pkg::HDR_GSV) begin
                    n_good  = 4'd0;
                    n_sats  = 7'd0;
                    n_total = 7'd1;
                end
            end else if (r_hdr == nrg_pkg::HDR_RMC && !cont) begin
                if (r_fidx == 5'd3) begin
                    n_lat_k = r_fcnt;
                    if (r_neg) begin
                        n_hemi[0] = !r_hemi[0];
                    end
                end else if (r_fidx == 5'd5) begin
                    n_lon_k = r_fcnt;
                    if (r_neg) begin
                        n_hemi[1] = !r_hemi[1];
                    end
                end
            end else if (gsvl) begin
                if (!cont && r_fidx == 5'd1) begin
                    n_total = v;
                end else if (!cont && r_fidx == 5'd3) begin
                    n_sats = v;
                end else if (r_fidx >= 5'd7 && r_fidx <= 5'd19 && r_fidx[1:0] == 2'b11
                             && r_sats != 7'd0) begin
                    n_sats = r_sats - 7'd1;
                    if (r_pos != 3'd0 && snr_good && r_good != 4'd15) begin
                        n_good = r_good + 4'd1;
                    end
                end
            end
            if (r_fidx != 5'd31) begin
                n_fidx = r_fidx + 5'd1;
            end
            n_pos   = 3'd0;
            n_phase = nrg_pkg::PH_LEAD;
            n_neg   = 1'b0;
            n_snr   = 7'd0;
            n_fcnt  = 3'd0;
            n_dot   = 1'b0;
        end

        // line end: result and fresh line
        if (nl) begin
            for (int j = 0; j < 12; j++) begin
                n_e0.td[4*j +: 4] = r_td[j];
            end
            n_e0.sat_ok = (n_good >= r_need);
            if (cont) begin
                n_left = r_left - 4'd1;
                if (r_left == 4'd1) begin
                    n_e0_v    = 1'b1;
                    n_e0.kind = nrg_pkg::KIND_GSV;
                end
            end else if (n_hdr == nrg_pkg::HDR_RMC) begin
                n_e0_v       = 1'b1;
                n_e0.kind    = nrg_pkg::KIND_RMC;
                n_e0.lat.d   = r_lat_d;
                n_e0.lat.r   = r_lat_r;
                n_e0.lat.f   = r_lat_f;
                n_e0.lat.k   = n_lat_k;
                n_e0.lat.neg = n_hemi[0];
                n_e0.lon.d   = r_lon_d;
                n_e0.lon.r   = r_lon_r;
                n_e0.lon.f   = r_lon_f;
                n_e0.lon.k   = n_lon_k;
                n_e0.lon.neg = n_hemi[1];
            end else if (n_hdr == nrg_pkg::HDR_GSV) begin
                tot = (n_total == 7'd0) ? 7'd1 : ((n_total > 7'd15) ? 7'd15 : n_total);
                if (tot == 7'd1) begin
                    n_e0_v    = 1'b1;
                    n_e0.kind = nrg_pkg::KIND_GSV;
                end else begin
                    n_left = 4'(tot - 7'd1);
                end
            end else begin
                n_e0_v    = 1'b1;
                n_e0.kind = nrg_pkg::KIND_SKIP;
            end
            n_fidx    = 5'd0;
            n_hdr     = nrg_pkg::HDR_NONE;
            n_past    = 1'b0;
            n_lat_d   = '0;  n_lat_r = '0;  n_lat_f = '0;  n_lat_k = '0;
            n_lon_d   = '0;  n_lon_r = '0;  n_lon_f = '0;  n_lon_k = '0;
            n_hemi    = 2'b00;
            for (int j = 0; j < 12; j++) begin
                n_td[j] = 4'd0;
            end
            n_may_rmc = 1'b1;
            n_may_gsv = 1'b1;
            n_pos     = 3'd0;
            n_phase   = nrg_pkg::PH_LEAD;
            n_neg     = 1'b0;
            n_snr     = 7'd0;
            n_fcnt    = 3'd0;
            n_dot     = 1'b0;
        end

        // number reader phases
        coord     = (r_hdr == nrg_pkg::HDR_RMC) && !cont;
        skip      = 1'b0;
        took_sign = 1'b0;
        num_int   = 1'b0;
        num_frac  = 1'b0;
        ph        = r_phase;
        if (r_phase == nrg_pkg::PH_LEAD) begin
            if (c == nrg_pkg::CH_SPACE || (c >= 8'd9 && c <= 8'd13)) begin
                skip = 1'b1;
            end else begin
                ph = nrg_pkg::PH_INT;
                if (c == nrg_pkg::CH_PLUS || c == nrg_pkg::CH_MINUS) begin
                    took_sign = 1'b1;
                end
            end
        end

        if (act) begin
            if (r_fidx == 5'd0 && !cont) begin
                if (r_pos < 3'd6) begin
                    if (c != nrg_pkg::hdr_char(1'b0, r_pos)) begin
                        n_may_rmc = 1'b0;
                    end
                    if (c != nrg_pkg::hdr_char(1'b1, r_pos)) begin
                        n_may_gsv = 1'b0;
                    end
                end
            end else if (coord) begin
                if (r_fidx == 5'd1) begin
                    if (c == nrg_pkg::CH_DOT) begin
                        n_dot = 1'b1;
                    end else if (!r_dot && r_pos < 3'd6 && dig) begin
                        n_td[4'(r_pos)] = dv;
                    end
                end else if (r_fidx == 5'd9) begin
                    if (r_pos < 3'd6 && dig) begin
                        n_td[4'(r_pos) + 4'd6] = dv;
                    end
                end else if (r_fidx == 5'd4) begin
                    if (r_pos == 3'd0 && c == nrg_pkg::CH_S) begin
                        n_hemi[0] = !r_hemi[0];
                    end
                end else if (r_fidx == 5'd6) begin
                    if (r_pos == 3'd0 && c == nrg_pkg::CH_W) begin
                        n_hemi[1] = !r_hemi[1];
                    end
                end
            end
            if ((r_fidx == 5'd3 || r_fidx == 5'd5) && coord || gsvl && !coord
                    && !(r_fidx == 5'd0 && !cont)) begin
                if (!skip) begin
                    n_phase = ph;
                    if (took_sign) begin
                        n_neg = (c == nrg_pkg::CH_MINUS);
                    end else if (ph == nrg_pkg::PH_INT) begin
                        if (dig) begin
                            num_int = 1'b1;
                        end else begin
                            n_phase = (coord && c == nrg_pkg::CH_DOT) ? nrg_pkg::PH_FRAC
                                                                       : nrg_pkg::PH_DONE;
                        end
                    end else if (ph == nrg_pkg::PH_FRAC) begin
                        if (!dig) begin
                            n_phase = nrg_pkg::PH_DONE;
                        end else if (r_fcnt < 3'(nrg_pkg::FRAC_DIGITS_MAX)) begin
                            num_frac = 1'b1;
                            n_fcnt   = r_fcnt + 3'd1;
                        end
                    end
                end
                if (!coord && num_int) begin
                    snr_t = 11'(r_snr) * 11'd10 + 11'(dv);
                    n_snr = (snr_t > 11'(nrg_pkg::SNR_CAP)) ? nrg_pkg::SNR_CAP : snr_t[6:0];
                end
                if (coord && r_fidx == 5'd3) begin
                    if (num_int) begin
                        cd      = nrg_pkg::coord_digit(r_lat_d, r_lat_r, dv);
                        n_lat_d = cd[23:7];
                        n_lat_r = cd[6:0];
                    end
                    if (num_frac) begin
                        n_lat_f = 17'(r_lat_f * 17'd10 + 17'(dv));
                    end
                end
                if (coord && r_fidx == 5'd5) begin
                    if (num_int) begin
                        cd      = nrg_pkg::coord_digit(r_lon_d, r_lon_r, dv);
                        n_lon_d = cd[23:7];
                        n_lon_r = cd[6:0];
                    end
                    if (num_frac) begin
                        n_lon_f = 17'(r_lon_f * 17'd10 + 17'(dv));
                    end
                end
            end
            if (r_pos != 3'd7) begin
                n_pos = r_pos + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fidx <= '0;  r_hdr <= nrg_pkg::HDR_NONE;  r_past <= 1'b0;  r_pos <= '0;
            r_phase <= nrg_pkg::PH_LEAD;  r_neg <= 1'b0;  r_may_rmc <= 1'b1;
            r_may_gsv <= 1'b1;  r_dot <= 1'b0;  r_hemi <= '0;  r_left <= '0;  r_sats <= '0;
            r_good <= '0;  r_snr <= '0;  r_total <= '0;  r_fcnt <= '0;
            r_lat_d <= '0;  r_lat_r <= '0;  r_lat_f <= '0;  r_lat_k <= '0;
            r_lon_d <= '0;  r_lon_r <= '0;  r_lon_f <= '0;  r_lon_k <= '0;
            for (int j = 0; j < 12; j++) begin
                r_td[j] <= 4'd0;
            end
        end else if (en) begin
            r_fidx <= n_fidx;  r_hdr <= n_hdr;  r_past <= n_past;  r_pos <= n_pos;
            r_phase <= n_phase;  r_neg <= n_neg;  r_may_rmc <= n_may_rmc;
            r_may_gsv <= n_may_gsv;  r_dot <= n_dot;  r_hemi <= n_hemi;  r_left <= n_left;
            r_sats <= n_sats;  r_good <= n_good;  r_snr <= n_snr;  r_total <= n_total;
            r_fcnt <= n_fcnt;
            r_lat_d <= n_lat_d;  r_lat_r <= n_lat_r;  r_lat_f <= n_lat_f;  r_lat_k <= n_lat_k;
            r_lon_d <= n_lon_d;  r_lon_r <= n_lon_r;  r_lon_f <= n_lon_f;  r_lon_k <= n_lon_k;
            r_td <= n_td;
        end
    end

    // result pipe
    always_comb begin
        n_pipe[1]         = r_pipe[0];
        n_pipe[1].hours   = nrg_pkg::pair_val(r_pipe[0].td[3:0], r_pipe[0].td[7:4],
                                              7'd0, 7'd23);
        n_pipe[1].minutes = nrg_pkg::pair_val(r_pipe[0].td[11:8], r_pipe[0].td[15:12],
                                              7'd0, 7'd59);
        n_pipe[1].seconds = nrg_pkg::pair_val(r_pipe[0].td[19:16], r_pipe[0].td[23:20],
                                              7'd0, 7'd60);
        n_pipe[1].day     = nrg_pkg::pair_val(r_pipe[0].td[27:24], r_pipe[0].td[31:28],
                                              7'd1, 7'd31);
        n_pipe[1].month   = nrg_pkg::pair_val(r_pipe[0].td[35:32], r_pipe[0].td[39:36],
                                              7'd1, 7'd12);
        n_pipe[1].year    = nrg_pkg::pair_val(r_pipe[0].td[43:40], r_pipe[0].td[47:44],
                                              7'd0, 7'd99);
        n_pipe[1].lat     = nrg_pkg::coord_s1(r_pipe[0].lat);
        n_pipe[1].lon     = nrg_pkg::coord_s1(r_pipe[0].lon);

        n_pipe[2]     = r_pipe[1];
        n_pipe[2].lat = nrg_pkg::coord_s2(r_pipe[1].lat);
        n_pipe[2].lon = nrg_pkg::coord_s2(r_pipe[1].lon);

        n_pipe[3]     = r_pipe[2];
        n_pipe[3].lat = nrg_pkg::coord_s3(r_pipe[2].lat);
        n_pipe[3].lon = nrg_pkg::coord_s3(r_pipe[2].lon);

        n_pipe[4]     = r_pipe[3];
        n_pipe[4].lat = nrg_pkg::coord_s4(r_pipe[3].lat);
        n_pipe[4].lon = nrg_pkg::coord_s4(r_pipe[3].lon);

        n_pipe[5]     = r_pipe[4];
        n_pipe[5].lat = nrg_pkg::coord_s5(r_pipe[4].lat, nrg_pkg::LAT_LIMIT);
        n_pipe[5].lon = nrg_pkg::coord_s5(r_pipe[4].lon, nrg_pkg::LON_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv        <= '0;
            o_out_valid <= 1'b0;
        end else if (en) begin
            r_pv        <= {r_pv[4:0], n_e0_v};
            o_out_valid <= r_pv[5];
        end
        if (en) begin
            r_pipe[0] <= n_e0;
            for (int j = 1; j < 6; j++) begin
                r_pipe[j] <= n_pipe[j];
            end
            o_line_kind      <= r_pipe[5].kind;
            o_satellites_ok  <= (r_pipe[5].kind == nrg_pkg::KIND_GSV) && r_pipe[5].sat_ok;
            o_hours          <= '0;
            o_minutes        <= '0;
            o_seconds        <= '0;
            o_day_of_month   <= '0;
            o_month          <= '0;
            o_year_two_digit <= '0;
            o_latitude_udeg  <= '0;
            o_longitude_udeg <= '0;
            if (r_pipe[5].kind == nrg_pkg::KIND_RMC) begin
                o_hours          <= r_pipe[5].hours[4:0];
                o_minutes        <= r_pipe[5].minutes[5:0];
                o_seconds        <= r_pipe[5].seconds[5:0];
                o_day_of_month   <= r_pipe[5].day[4:0];
                o_month          <= r_pipe[5].month[3:0];
                o_year_two_digit <= r_pipe[5].year;
                o_latitude_udeg  <= r_pipe[5].lat.neg ? 28'(29'd0 - r_pipe[5].lat.mag)
                                                      : r_pipe[5].lat.mag[27:0];
                o_longitude_udeg <= r_pipe[5].lon.neg ? (29'd0 - r_pipe[5].lon.mag)
                                                      : r_pipe[5].lon.mag;
            end
        end
    end

`ifndef SYNTHESIS
    a_cont_no_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left != 4'd0) |-> (r_hdr == nrg_pkg::HDR_NONE))
        else $error("header recognised inside a GSV group");

    a_minutes_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lat_r < 7'd100) && (r_lon_r < 7'd100) && (r_lat_d <= 17'(nrg_pkg::DEG_CAP)))
        else $error("degree/minute split out of range");

    a_lat_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv[5] && (r_pipe[5].kind == nrg_pkg::KIND_RMC)
        |-> (r_pipe[5].lat.mag <= nrg_pkg::LAT_LIMIT))
        else $error("latitude not saturated");

    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_pv))
        else $error("result pipe moved while stalled");
`endif

endmodule

// ===== tb/nrg_checker.sv =====
`timescale 1ns / 100ps

module nrg_checker
    import nrg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_line_kind,
    input  logic [4:0]  i_hours,
    input  logic [5:0]  i_minutes,
    input  logic [5:0]  i_seconds,
    input  logic [4:0]  i_day_of_month,
    input  logic [3:0]  i_month,
    input  logic [6:0]  i_year_two_digit,
    input  logic signed [27:0] i_latitude_udeg,
    input  logic signed [28:0] i_longitude_udeg,
    input  logic        i_satellites_ok,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  hh;
        logic [5:0]  mm;
        logic [5:0]  ss;
        logic [4:0]  dd;
        logic [3:0]  mo;
        logic [6:0]  yy;
        logic [27:0] lat;
        logic [28:0] lon;
        logic        sok;
    } t_line_res;

    t_line_res line_q[$];

    // parser state
    logic [6:0]  thr;
    logic [3:0]  need;
    int unsigned fidx, hdr, star, fpos, phase, nfrac, hemi;
    int unsigned lines_left, sats_left, good, grp_total;
    bit          neg, maybe_rmc, maybe_gsv, dot_seen;
    longint unsigned lat_acc, lon_acc, snr_acc;
    int unsigned td[12];

    function automatic logic [7:0] hdr_byte(bit gsv, int unsigned p);
        string s;
        s = gsv ? "$GPGSV" : "$GPRMC";
        return s[p];
    endfunction

    task automatic new_field();
        fpos = 0; phase = 0; neg = 0; snr_acc = 0; nfrac = 0; dot_seen = 0;
    endtask

    task automatic new_line();
        fidx = 0; hdr = HDR_NONE; star = 0; lat_acc = 0; lon_acc = 0; hemi = 0;
        foreach (td[i]) td[i] = 0;
        maybe_rmc = 1; maybe_gsv = 1;
        new_field();
    endtask

    task automatic take_digit(logic [7:0] c, ref longint unsigned acc, input bit coord);
        bit dig;
        longint unsigned cap;
        dig = c >= "0" && c <= "9";
        cap = coord ? 9999999 : 127;
        if (phase == 0) begin
            if (c == CH_SPACE || (c >= 9 && c <= 13)) return;
            phase = 1;
            if (c == CH_PLUS || c == CH_MINUS) begin
                neg = (c == CH_MINUS);
                return;
            end
        end
        if (phase == 1) begin
            if (dig) begin
                acc = acc * 10 + (c - "0");
                if (acc > cap) acc = cap;
            end else begin
                phase = (coord && c == CH_DOT) ? 3 : 2;
            end
        end else if (phase == 3) begin
            if (!dig) phase = 2;
            else if (nfrac < FRAC_DIGITS_MAX) begin
                acc = acc * 10 + (c - "0");
                nfrac++;
            end
        end
    endtask

    task automatic close_field(bit by_comma);
        bit cont;
        int unsigned v;
        int s;
        longint unsigned pad;
        cont = lines_left > 0;
        pad = 1;
        repeat (FRAC_DIGITS_MAX - nfrac) pad *= 10;
        if (fidx == 0 && !cont) begin
            hdr = HDR_NONE;
            if (by_comma && fpos == 6)
                hdr = maybe_rmc ? HDR_RMC : (maybe_gsv ? HDR_GSV : HDR_NONE);
            if (hdr == HDR_GSV) begin
                good = 0; sats_left = 0; grp_total = 1;
            end
        end else if (hdr == HDR_RMC && !cont) begin
            if (fidx == 3) begin
                lat_acc *= pad;
                if (neg) hemi ^= 1;
            end else if (fidx == 5) begin
                lon_acc *= pad;
                if (neg) hemi ^= 2;
            end
        end else if (cont || hdr == HDR_GSV) begin
            v = neg ? 0 : int'(snr_acc);
            if (!cont && fidx == 1) grp_total = v;
            else if (!cont && fidx == 3) sats_left = v;
            else if (fidx >= 7 && fidx <= 19 && ((fidx - 7) % 4) == 0 && sats_left > 0) begin
                sats_left--;
                if (fpos > 0) begin
                    s = neg ? -int'(snr_acc) : int'(snr_acc);
                    if (s >= int'(thr) && good < 15) good++;
                end
            end
        end
        if (fidx < 31) fidx++;
        new_field();
    endtask

    function automatic longint signed udeg(longint unsigned acc, bit ng, longint unsigned lim);
        longint unsigned whole, mins, q, val;
        whole = acc / 100000;
        mins  = (whole % 100) * 100000 + acc % 100000;
        q     = (2 * mins * 1000000 + 6000000) / 12000000;
        val   = (whole / 100) * 1000000 + q;
        if (val > lim) val = lim;
        return ng ? -longint'(val) : longint'(val);
    endfunction

    function automatic int unsigned two_digits(int i, int unsigned lo, int unsigned hi);
        int unsigned v;
        v = td[i] * 10 + td[i + 1];
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic t_line_res gsv_done();
        t_line_res r;
        r = '0;
        r.kind = KIND_GSV;
        r.sok  = good >= need;
        return r;
    endfunction

    task automatic feed_byte(logic [7:0] c);
        bit cont, gline, dig;
        t_line_res r;
        int unsigned t;
        cont  = lines_left > 0;
        gline = cont || hdr == HDR_GSV;
        if (c == CH_LF) begin
            if (!star) close_field(0);
            if (cont) begin
                lines_left--;
                if (lines_left == 0) line_q.push_back(gsv_done());
            end else if (hdr == HDR_RMC) begin
                r = '0;
                r.kind = KIND_RMC;
                r.hh = two_digits(0, 0, 23);
                r.mm = two_digits(2, 0, 59);
                r.ss = two_digits(4, 0, 60);
                r.dd = two_digits(6, 1, 31);
                r.mo = two_digits(8, 1, 12);
                r.yy = two_digits(10, 0, 99);
                r.lat = 28'(udeg(lat_acc, hemi[0], LAT_LIMIT));
                r.lon = 29'(udeg(lon_acc, hemi[1], LON_LIMIT));
                line_q.push_back(r);
            end else if (hdr == HDR_GSV) begin
                t = grp_total < 1 ? 1 : (grp_total > 15 ? 15 : grp_total);
                if (t == 1) line_q.push_back(gsv_done());
                else lines_left = t - 1;
            end else begin
                r = '0;
                r.kind = KIND_SKIP;
                line_q.push_back(r);
            end
            new_line();
            return;
        end
        if (star) return;
        if (c == CH_STAR && gline) begin
            close_field(1);
            star = 1;
            return;
        end
        if (c == CH_COMMA) begin
            close_field(1);
            return;
        end
        dig = c >= "0" && c <= "9";
        if (fidx == 0 && !cont) begin
            if (fpos < 6) begin
                if (c != hdr_byte(0, fpos)) maybe_rmc = 0;
                if (c != hdr_byte(1, fpos)) maybe_gsv = 0;
            end
        end else if (hdr == HDR_RMC && !cont) begin
            if (fidx == 1) begin
                if (c == CH_DOT) dot_seen = 1;
                else if (!dot_seen && fpos < 6 && dig) td[fpos] = c - "0";
            end else if (fidx == 9) begin
                if (fpos < 6 && dig) td[6 + fpos] = c - "0";
            end else if (fidx == 3) take_digit(c, lat_acc, 1);
            else if (fidx == 5) take_digit(c, lon_acc, 1);
            else if (fidx == 4 && fpos == 0 && c == CH_S) hemi ^= 1;
            else if (fidx == 6 && fpos == 0 && c == CH_W) hemi ^= 2;
        end else if (gline) begin
            take_digit(c, snr_acc, 0);
        end
        if (fpos < 255) fpos++;
    endtask

    t_line_res got, want;

    always_comb o_pending = line_q.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thr = 30; need = 3;
            lines_left = 0; sats_left = 0; good = 0; grp_total = 0;
            new_line();
            line_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_SNR_THR) thr = i_cfg_data;
                else need = i_cfg_data[3:0];
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_line_kind, i_hours, i_minutes, i_seconds, i_day_of_month, i_month,
                        i_year_two_digit, i_latitude_udeg, i_longitude_udeg, i_satellites_ok};
                if (line_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result %p", got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = line_q.pop_front();
                    if (got !== want) begin
                        if (o_errors < 10) $display("mismatch: exp %p got %p", want, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) feed_byte(i_text_byte);
        end
    end

endmodule

// ===== tb/tb_nmea_rmc_gsv_parser.sv =====
`timescale 1ns / 100ps

module tb_nmea_rmc_gsv_parser;
    import nrg_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        cfg_we = 0;
    logic        cfg_addr = 0;
    logic [6:0]  cfg_data = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [7:0]  text_byte = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [1:0]  line_kind;
    logic [4:0]  hours, day;
    logic [5:0]  mins, secs;
    logic [3:0]  month;
    logic [6:0]  year;
    logic signed [27:0] lat;
    logic signed [28:0] lon;
    logic        sat_ok;
    int          errors, pending;
    int          burst_left = 0;
    int          bytes_sent = 0;

    always #5 i_clk = ~i_clk;

    nmea_rmc_gsv_parser i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr),
        .i_cfg_data(cfg_data), .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_text_byte(text_byte), .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_line_kind(line_kind), .o_hours(hours), .o_minutes(mins), .o_seconds(secs),
        .o_day_of_month(day), .o_month(month), .o_year_two_digit(year),
        .o_latitude_udeg(lat), .o_longitude_udeg(lon), .o_satellites_ok(sat_ok)
    );

    nrg_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr),
        .i_cfg_data(cfg_data), .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_text_byte(text_byte), .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_line_kind(line_kind), .i_hours(hours), .i_minutes(mins), .i_seconds(secs),
        .i_day_of_month(day), .i_month(month), .i_year_two_digit(year),
        .i_latitude_udeg(lat), .i_longitude_udeg(lon), .i_satellites_ok(sat_ok),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver stall pattern: long quiet stretches, then busy ones
    int stall_mode = 0;
    always @(negedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       out_stall <= 0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 5) != 0);
        endcase
    end

    task automatic send_byte(logic [7:0] b);
        @(negedge i_clk);
        if (burst_left == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(0, 4)) @(negedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        in_valid  <= 1;
        text_byte <= b;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic drain_lines();
        @(negedge i_clk);
        in_valid <= 0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] val);
        drain_lines();
        cfg_we <= 1; cfg_addr <= idx; cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 0;
    endtask

    function automatic string num_str(int lo, int hi);
        return $sformatf("%0d", $urandom_range(lo, hi));
    endfunction

    function automatic string rand_coord(int deg_hi);
        string s;
        s = $sformatf("%0d%02d", $urandom_range(0, deg_hi), $urandom_range(0, 60));
        if ($urandom_range(0, 5) != 0) begin
            s = {s, "."};
            repeat ($urandom_range(0, 7)) s = {s, num_str(0, 9)};
        end
        if ($urandom_range(0, 9) == 0) s = {"-", s};
        if ($urandom_range(0, 9) == 0) s = {" ", s};
        return s;
    endfunction

    function automatic string rmc_line();
        return $sformatf("$GPRMC,%02d%02d%02d.%0d,A,%s,%s,%s,%s,0.1,54.7,%02d%02d%02d,,*6A\n",
            $urandom_range(0, 29), $urandom_range(0, 69), $urandom_range(0, 69),
            $urandom_range(0, 99), rand_coord(99),
            ($urandom_range(0, 1) ? "S" : "N"), rand_coord(199),
            ($urandom_range(0, 1) ? "W" : "E"), $urandom_range(0, 39),
            $urandom_range(0, 19), $urandom_range(0, 99));
    endfunction

    function automatic string snr_field();
        case ($urandom_range(0, 9))
            0:       return "";
            1:       return $sformatf("-%0d", $urandom_range(0, 50));
            2:       return num_str(100, 300);
            default: return num_str(0, 60);
        endcase
    endfunction

    function automatic string gsv_line(int total, int idx, int sats);
        string s;
        s = $sformatf("$GPGSV,%0d,%0d,%0d", total, idx, sats);
        for (int k = 0; k < 4; k++)
            s = {s, $sformatf(",%0d,%0d,%0d,%s", $urandom_range(1, 32),
                 $urandom_range(0, 90), $urandom_range(0, 359), snr_field())};
        if ($urandom_range(0, 1)) s = {s, "*7", num_str(0, 9), ",55"};
        return {s, "\n"};
    endfunction

    function automatic string noise_line();
        string s;
        s = "";
        repeat ($urandom_range(0, 12)) s = {s, string'(8'($urandom_range(11, 255)))};
        return {s, "\n"};
    endfunction

    task automatic send_random_sentence();
        int total;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: send_text(rmc_line());
            4, 5, 6: begin
                total = $urandom_range(1, 4);
                for (int i = 1; i <= total; i++)
                    send_text(gsv_line(total, i, $urandom_range(0, 16)));
            end
            7: send_text(gsv_line($urandom_range(0, 1) ? 0 : -2, 1, $urandom_range(0, 5)));
            8: send_text(noise_line());
            default: send_text({"$GPRMC", num_str(0, 9), ",1,2\n"});
        endcase
    endtask

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        // directed lines
        send_text("$GPRMC,235960.99,A,8959.99999,N,17959.999995,E,0,0,311299,,*6A\n");
        send_text("$GPRMC,999999,A,9999999.9999999,S,9999999,W,,,000000\n");
        send_text("$GPRMC,,A,+0000.000005,N,-1234.5,E,,,\n");
        send_text("$GPRMC\n");
        send_text("$GPGSV,1,1,04,1,2,3,30,4,5,6,29,7,8,9,,10,11,12,99*7F\n");
        send_text("$GPGSV,2,1,05,1,2,3,45,4,5,6,45,7,8,9,-45,1,1,1,45\n");
        send_text("garbage,x,y*z\n$GPGSV,2,2,05,1,2,3,45,4,5,6,45\n");
        send_text("$GPGSV,20,1,99,1,2,3,127\n");
        for (int i = 0; i < 14; i++) send_text("\n");
        send_text({string'(8'hFF), string'(8'h00), string'(8'h80), "\n"});
        write_reg(CFG_SNR_THR, 7'd0);
        write_reg(CFG_GOOD_SATS, 4'd1);
        send_text("$GPGSV,1,1,4,1,2,3,0,4,5,6,,7,8,9,0\n");
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin write_reg(CFG_SNR_THR, 7'd99);  write_reg(CFG_GOOD_SATS, 4'd15); end
                1: begin write_reg(CFG_SNR_THR, 7'd127); write_reg(CFG_GOOD_SATS, 4'd0);  end
                2: begin write_reg(CFG_SNR_THR, 7'd30);  write_reg(CFG_GOOD_SATS, 4'd3);  end
                default: begin
                    write_reg(CFG_SNR_THR, 7'($urandom_range(0, 99)));
                    write_reg(CFG_GOOD_SATS, 4'($urandom_range(1, 4)));
                end
            endcase
            repeat (25) send_random_sentence();
        end
        drain_lines();
        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule
